>>> design/ssu_pkg.sv
// ssu_pkg: constants and the object code type for the surface shading unit
// depends on nothing; every module refers to it by scoped names

package ssu_pkg;

   // vector input width and the rescaled component magnitude width
   localparam int VEC_WIDTH = 32;
   localparam int NORM_BITS = 15;
   localparam int LEN_W     = $clog2(VEC_WIDTH + 1);

   // dot product and squared length widths
   localparam int COMP_W = NORM_BITS + 1;
   localparam int PROD_W = 2 * COMP_W;
   localparam int DOT_W  = PROD_W + 2;
   localparam int SQ_W   = 2 * NORM_BITS + 2;
   localparam int AD_W   = SQ_W;
   localparam int NL_W   = 2 * SQ_W;

   // square root and quotient
   localparam int ROOT_W     = SQ_W;
   localparam int REM_W      = ROOT_W + 3;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int FRAC       = 16;
   localparam int Q_W        = FRAC + 1;
   localparam int NUM_W      = AD_W + FRAC;
   localparam int DIV_STEPS  = Q_W;

   // highlight power terms
   localparam int T_W       = Q_W;
   localparam int COEF_W    = 21;
   localparam int STEP_W    = 3;
   localparam int POW_STEPS = 6;
   localparam int CHAN_W    = 8;
   localparam int CPROD_W   = CHAN_W + COEF_W;

   localparam logic [Q_W-1:0] ONE_Q16   = Q_W'(65536);
   localparam logic [Q_W-1:0] BOX_WHITE = Q_W'(65471);
   localparam int OFS_SPHERE = 19661;
   localparam int OFS_BOX    = 6554;
   localparam int OFS_TETRA  = 39322;
   localparam logic [STEP_W-1:0] STEPS_SPHERE = STEP_W'(2);
   localparam logic [STEP_W-1:0] STEPS_BOX    = STEP_W'(6);
   localparam logic [STEP_W-1:0] STEPS_TETRA  = STEP_W'(5);

   typedef enum logic [1:0] {
      OBJ_UNKNOWN = 2'd0,
      OBJ_SPHERE  = 2'd1,
      OBJ_BOX     = 2'd2,
      OBJ_TETRA   = 2'd3
   } obj_kind_type;

endpackage

>>> design/surface_shading_unit.sv
// surface_shading_unit: per-hit diffuse and power-highlight shading pipeline
// depends on ssu_pkg (widths, fixed-point constants, object codes)
// throughput: one beat per cycle while no rsp beat is held; the 32-stage square
// root and 17-stage divider are fully pipelined, one result bit per stage
// rsp_stall while rsp_valid is high freezes every stage at once and raises
// req_stall; nothing is dropped
// reset is synchronous: it clears all valid bits, payload registers keep old data

module surface_shading_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [ssu_pkg::VEC_WIDTH-1:0] req_normal_x,
   input  logic signed [ssu_pkg::VEC_WIDTH-1:0] req_normal_y,
   input  logic signed [ssu_pkg::VEC_WIDTH-1:0] req_normal_z,
   input  logic signed [ssu_pkg::VEC_WIDTH-1:0] req_light_x,
   input  logic signed [ssu_pkg::VEC_WIDTH-1:0] req_light_y,
   input  logic signed [ssu_pkg::VEC_WIDTH-1:0] req_light_z,
   input  logic req_surface_kind,
   input  logic [1:0] req_object_kind,
   input  logic req_in_shadow,
   input  logic [7:0] req_base_red,
   input  logic [7:0] req_base_green,
   input  logic [7:0] req_base_blue,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [7:0] rsp_lit_red,
   output logic [7:0] rsp_lit_green,
   output logic [7:0] rsp_lit_blue,
   output logic rsp_kind_error
);

   typedef logic [ssu_pkg::VEC_WIDTH-1:0] mag_type;
   typedef logic [ssu_pkg::LEN_W-1:0] len_type;

   typedef struct packed {
      logic shadow;
      logic shiny;
      ssu_pkg::obj_kind_type obj;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic zero;
   } side_type;

   typedef struct packed {
      side_type side;
      logic neg;
      logic [ssu_pkg::AD_W-1:0] ad;
      logic [ssu_pkg::NL_W-1:0] v;
      logic [ssu_pkg::REM_W-1:0] rem;
      logic [ssu_pkg::ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      side_type side;
      logic neg;
      logic [ssu_pkg::ROOT_W-1:0] s;
      logic [ssu_pkg::NUM_W-1:0] nrem;
      logic [ssu_pkg::Q_W-1:0] q;
   } dv_type;

   typedef struct packed {
      logic blk;
      logic err;
      logic white;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [ssu_pkg::T_W-1:0] t;
      logic [ssu_pkg::STEP_W-1:0] steps;
      logic [ssu_pkg::COEF_W-1:0] p;
   } post_type;

   function automatic mag_type mag_of(input mag_type v);
      return v[ssu_pkg::VEC_WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic len_type bit_len(input mag_type m);
      len_type r;
      r = '0;
      for (int i = 0; i < ssu_pkg::VEC_WIDTH; i++) begin
         if (m[i]) r = len_type'(i + 1);
      end
      return r;
   endfunction

   function automatic logic signed [ssu_pkg::COMP_W-1:0] rescale(
      input mag_type m, input len_type len, input logic neg);
      mag_type s;
      logic signed [ssu_pkg::COMP_W-1:0] u;
      if (len > len_type'(ssu_pkg::NORM_BITS)) begin
         s = m >> (len - len_type'(ssu_pkg::NORM_BITS));
      end else begin
         s = m << (len_type'(ssu_pkg::NORM_BITS) - len);
      end
      u = {1'b0, s[ssu_pkg::NORM_BITS-1:0]};
      return neg ? -u : u;
   endfunction

   // global advance: the whole pipe moves unless a finished beat is held
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   // stage a: magnitudes, signs and bit length of each vector
   mag_type raw [2][3];
   assign raw[0][0] = req_normal_x;
   assign raw[0][1] = req_normal_y;
   assign raw[0][2] = req_normal_z;
   assign raw[1][0] = req_light_x;
   assign raw[1][1] = req_light_y;
   assign raw[1][2] = req_light_z;

   mag_type  a_mag_in [2][3];
   mag_type  a_mag_ff [2][3];
   logic     a_neg_ff [2][3];
   len_type  a_len_in [2];
   len_type  a_len_ff [2];
   side_type a_side_in, a_side_ff;
   logic     a_vld_ff;

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int c = 0; c < 3; c++) a_mag_in[v][c] = mag_of(raw[v][c]);
         a_len_in[v] = bit_len(a_mag_in[v][0] | a_mag_in[v][1] | a_mag_in[v][2]);
      end
      a_side_in.shadow = req_in_shadow;
      a_side_in.shiny  = req_surface_kind;
      a_side_in.obj    = ssu_pkg::obj_kind_type'(req_object_kind);
      a_side_in.red    = req_base_red;
      a_side_in.green  = req_base_green;
      a_side_in.blue   = req_base_blue;
      a_side_in.zero   = 1'b0;
   end

   // stage b: common rescale of each vector to 15-bit magnitudes
   logic signed [ssu_pkg::COMP_W-1:0] b_comp_in [2][3];
   logic signed [ssu_pkg::COMP_W-1:0] b_comp_ff [2][3];
   side_type b_side_in, b_side_ff;
   logic     b_vld_ff;

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int c = 0; c < 3; c++) begin
            b_comp_in[v][c] = rescale(a_mag_ff[v][c], a_len_ff[v], a_neg_ff[v][c]);
         end
      end
      b_side_in      = a_side_ff;
      b_side_in.zero = (a_len_ff[0] == '0) || (a_len_ff[1] == '0);
   end

   // stage c: nine component products
   logic signed [ssu_pkg::PROD_W-1:0] c_dp_in [3];
   logic signed [ssu_pkg::PROD_W-1:0] c_dp_ff [3];
   logic signed [ssu_pkg::PROD_W-1:0] c_nsq_in [3];
   logic signed [ssu_pkg::PROD_W-1:0] c_lsq_in [3];
   logic [2*ssu_pkg::NORM_BITS-1:0] c_nsq_ff [3];
   logic [2*ssu_pkg::NORM_BITS-1:0] c_lsq_ff [3];
   side_type c_side_ff;
   logic     c_vld_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         c_dp_in[c]  = b_comp_ff[0][c] * b_comp_ff[1][c];
         c_nsq_in[c] = b_comp_ff[0][c] * b_comp_ff[0][c];
         c_lsq_in[c] = b_comp_ff[1][c] * b_comp_ff[1][c];
      end
   end

   // stage d: dot product and squared lengths
   logic signed [ssu_pkg::DOT_W-1:0] d_sum;
   logic signed [ssu_pkg::DOT_W-1:0] d_abs;
   logic [ssu_pkg::SQ_W-1:0] d_nn_in, d_ll_in, d_nn_ff, d_ll_ff;
   logic [ssu_pkg::AD_W-1:0] d_ad_ff;
   logic     d_neg_ff;
   side_type d_side_ff;
   logic     d_vld_ff;

   always_comb begin
      d_sum = ssu_pkg::DOT_W'(c_dp_ff[0]) + ssu_pkg::DOT_W'(c_dp_ff[1])
            + ssu_pkg::DOT_W'(c_dp_ff[2]);
      d_abs = d_sum[ssu_pkg::DOT_W-1] ? -d_sum : d_sum;
      d_nn_in = ssu_pkg::SQ_W'(c_nsq_ff[0]) + ssu_pkg::SQ_W'(c_nsq_ff[1])
              + ssu_pkg::SQ_W'(c_nsq_ff[2]);
      d_ll_in = ssu_pkg::SQ_W'(c_lsq_ff[0]) + ssu_pkg::SQ_W'(c_lsq_ff[1])
              + ssu_pkg::SQ_W'(c_lsq_ff[2]);
   end

   // stage e: product of the squared lengths
   logic [ssu_pkg::NL_W-1:0] e_nl_in, e_nl_ff;
   logic [ssu_pkg::AD_W-1:0] e_ad_ff;
   logic     e_neg_ff;
   side_type e_side_ff;
   logic     e_vld_ff;

   assign e_nl_in = d_nn_ff * d_ll_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
         b_vld_ff <= a_vld_ff;
         c_vld_ff <= b_vld_ff;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
      end
      if (adv) begin
         for (int v = 0; v < 2; v++) begin
            for (int c = 0; c < 3; c++) begin
               a_mag_ff[v][c]  <= a_mag_in[v][c];
               a_neg_ff[v][c]  <= raw[v][c][ssu_pkg::VEC_WIDTH-1];
               b_comp_ff[v][c] <= b_comp_in[v][c];
            end
            a_len_ff[v] <= a_len_in[v];
         end
         a_side_ff <= a_side_in;
         b_side_ff <= b_side_in;
         for (int c = 0; c < 3; c++) begin
            c_dp_ff[c]  <= c_dp_in[c];
            c_nsq_ff[c] <= c_nsq_in[c][2*ssu_pkg::NORM_BITS-1:0];
            c_lsq_ff[c] <= c_lsq_in[c][2*ssu_pkg::NORM_BITS-1:0];
         end
         c_side_ff <= b_side_ff;
         d_neg_ff  <= d_sum[ssu_pkg::DOT_W-1];
         d_ad_ff   <= d_abs[ssu_pkg::AD_W-1:0];
         d_nn_ff   <= d_nn_in;
         d_ll_ff   <= d_ll_in;
         d_side_ff <= c_side_ff;
         e_nl_ff   <= e_nl_in;
         e_ad_ff   <= d_ad_ff;
         e_neg_ff  <= d_neg_ff;
         e_side_ff <= d_side_ff;
      end
   end

   // square root pipeline: one root bit per stage
   sq_type sq_src [ssu_pkg::SQRT_STEPS];
   sq_type sq_in  [ssu_pkg::SQRT_STEPS];
   sq_type sq_ff  [ssu_pkg::SQRT_STEPS];
   logic   sq_vld_ff [ssu_pkg::SQRT_STEPS];
   sq_type sq_seed;

   always_comb begin
      sq_seed.side = e_side_ff;
      sq_seed.neg  = e_neg_ff;
      sq_seed.ad   = e_ad_ff;
      sq_seed.v    = e_nl_ff;
      sq_seed.rem  = '0;
      sq_seed.root = '0;
   end

   for (genvar k = 0; k < ssu_pkg::SQRT_STEPS; k++) begin : g_sqrt
      logic [ssu_pkg::REM_W-1:0] rem_sh;
      logic [ssu_pkg::REM_W-1:0] trial;
      if (k == 0) begin : g_head
         assign sq_src[k] = sq_seed;
      end else begin : g_link
         assign sq_src[k] = sq_ff[k-1];
      end
      always_comb begin
         rem_sh = {sq_src[k].rem[ssu_pkg::REM_W-3:0], sq_src[k].v[ssu_pkg::NL_W-1 -: 2]};
         trial  = ssu_pkg::REM_W'({sq_src[k].root, 2'b01});
         sq_in[k]   = sq_src[k];
         sq_in[k].v = {sq_src[k].v[ssu_pkg::NL_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            sq_in[k].rem  = rem_sh - trial;
            sq_in[k].root = {sq_src[k].root[ssu_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            sq_in[k].rem  = rem_sh;
            sq_in[k].root = {sq_src[k].root[ssu_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ssu_pkg::SQRT_STEPS; k++) sq_vld_ff[k] <= 1'b0;
      end else if (adv) begin
         sq_vld_ff[0] <= e_vld_ff;
         for (int k = 1; k < ssu_pkg::SQRT_STEPS; k++) sq_vld_ff[k] <= sq_vld_ff[k-1];
      end
      if (adv) begin
         for (int k = 0; k < ssu_pkg::SQRT_STEPS; k++) sq_ff[k] <= sq_in[k];
      end
   end

   // divider pipeline: |d| * 2^16 / root, one quotient bit per stage
   dv_type dv_src [ssu_pkg::DIV_STEPS];
   dv_type dv_in  [ssu_pkg::DIV_STEPS];
   dv_type dv_ff  [ssu_pkg::DIV_STEPS];
   logic   dv_vld_ff [ssu_pkg::DIV_STEPS];
   dv_type dv_seed;

   always_comb begin
      dv_seed.side = sq_ff[ssu_pkg::SQRT_STEPS-1].side;
      dv_seed.neg  = sq_ff[ssu_pkg::SQRT_STEPS-1].neg;
      dv_seed.s    = sq_ff[ssu_pkg::SQRT_STEPS-1].root;
      dv_seed.nrem = {sq_ff[ssu_pkg::SQRT_STEPS-1].ad, ssu_pkg::FRAC'(0)};
      dv_seed.q    = '0;
   end

   for (genvar j = 0; j < ssu_pkg::DIV_STEPS; j++) begin : g_div
      localparam int SH = ssu_pkg::Q_W - 1 - j;
      logic [ssu_pkg::NUM_W:0] dsh;
      if (j == 0) begin : g_head
         assign dv_src[j] = dv_seed;
      end else begin : g_link
         assign dv_src[j] = dv_ff[j-1];
      end
      always_comb begin
         dsh = (ssu_pkg::NUM_W + 1)'(dv_src[j].s) << SH;
         dv_in[j] = dv_src[j];
         if ({1'b0, dv_src[j].nrem} >= dsh) begin
            dv_in[j].nrem  = dv_src[j].nrem - dsh[ssu_pkg::NUM_W-1:0];
            dv_in[j].q[SH] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ssu_pkg::DIV_STEPS; j++) dv_vld_ff[j] <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= sq_vld_ff[ssu_pkg::SQRT_STEPS-1];
         for (int j = 1; j < ssu_pkg::DIV_STEPS; j++) dv_vld_ff[j] <= dv_vld_ff[j-1];
      end
      if (adv) begin
         for (int j = 0; j < ssu_pkg::DIV_STEPS; j++) dv_ff[j] <= dv_in[j];
      end
   end

   // stage t: signed cosine, offset term, black and white decisions
   dv_type dv_last;
   logic [ssu_pkg::Q_W-1:0] t_q;
   logic signed [ssu_pkg::Q_W:0]   t_cos;
   logic signed [ssu_pkg::Q_W+1:0] t_full;
   logic signed [ssu_pkg::Q_W+1:0] t_ofs;
   logic [ssu_pkg::STEP_W-1:0] t_pw;
   logic t_err;
   post_type t_in, t_ff;
   logic t_vld_ff;

   assign dv_last = dv_ff[ssu_pkg::DIV_STEPS-1];

   always_comb begin
      t_q   = (dv_last.q > ssu_pkg::ONE_Q16) ? ssu_pkg::ONE_Q16 : dv_last.q;
      t_cos = dv_last.neg ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});
      case (dv_last.side.obj)
         ssu_pkg::OBJ_SPHERE: begin
            t_ofs = (ssu_pkg::Q_W + 2)'(ssu_pkg::OFS_SPHERE);
            t_pw  = ssu_pkg::STEPS_SPHERE;
         end
         ssu_pkg::OBJ_BOX: begin
            t_ofs = (ssu_pkg::Q_W + 2)'(ssu_pkg::OFS_BOX);
            t_pw  = ssu_pkg::STEPS_BOX;
         end
         default: begin
            t_ofs = (ssu_pkg::Q_W + 2)'(ssu_pkg::OFS_TETRA);
            t_pw  = ssu_pkg::STEPS_TETRA;
         end
      endcase
      t_full = (ssu_pkg::Q_W + 2)'(t_cos) + t_ofs;
      t_err  = !dv_last.side.shadow && dv_last.side.shiny
               && (dv_last.side.obj == ssu_pkg::OBJ_UNKNOWN);
      t_in.err   = t_err;
      t_in.blk   = dv_last.side.shadow || t_err || dv_last.side.zero
                   || (dv_last.side.shiny ? (t_full <= 0)
                                          : (dv_last.neg || (t_q == '0)));
      t_in.white = dv_last.side.shiny && (dv_last.side.obj == ssu_pkg::OBJ_BOX)
                   && !dv_last.neg && (t_q >= ssu_pkg::BOX_WHITE);
      t_in.red   = dv_last.side.red;
      t_in.green = dv_last.side.green;
      t_in.blue  = dv_last.side.blue;
      t_in.t     = t_full[ssu_pkg::T_W-1:0];
      t_in.steps = dv_last.side.shiny ? t_pw : '0;
      t_in.p     = dv_last.side.shiny ? ssu_pkg::COEF_W'(t_full[ssu_pkg::T_W-1:0])
                                      : ssu_pkg::COEF_W'(t_q);
   end

   // power stages: p = (p * t) >> 16 while steps remain
   post_type pw_src [ssu_pkg::POW_STEPS];
   post_type pw_in  [ssu_pkg::POW_STEPS];
   post_type pw_ff  [ssu_pkg::POW_STEPS];
   logic     pw_vld_ff [ssu_pkg::POW_STEPS];

   for (genvar i = 0; i < ssu_pkg::POW_STEPS; i++) begin : g_pow
      logic [ssu_pkg::COEF_W+ssu_pkg::T_W-1:0] prod;
      if (i == 0) begin : g_head
         assign pw_src[i] = t_ff;
      end else begin : g_link
         assign pw_src[i] = pw_ff[i-1];
      end
      always_comb begin
         prod = pw_src[i].p * pw_src[i].t;
         pw_in[i] = pw_src[i];
         if (pw_src[i].steps > ssu_pkg::STEP_W'(i)) begin
            pw_in[i].p = prod[ssu_pkg::FRAC +: ssu_pkg::COEF_W];
         end
      end
   end

   // stage m: per-channel scale by the coefficient
   post_type pw_last;
   logic [7:0] m_base [3];
   logic [ssu_pkg::CPROD_W-1:0] m_prod_in [3];
   logic [ssu_pkg::CPROD_W-1:0] m_prod_ff [3];
   logic m_blk_ff, m_err_ff, m_vld_ff;

   assign pw_last = pw_ff[ssu_pkg::POW_STEPS-1];

   always_comb begin
      m_base[0] = pw_last.white ? 8'hFF : pw_last.red;
      m_base[1] = pw_last.white ? 8'hFF : pw_last.green;
      m_base[2] = pw_last.white ? 8'hFF : pw_last.blue;
      for (int c = 0; c < 3; c++) m_prod_in[c] = m_base[c] * pw_last.p;
   end

   // output stage: truncate, saturate and force black
   logic [7:0] o_chan_in [3];
   logic [7:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic rsp_err_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (m_blk_ff) begin
            o_chan_in[c] = '0;
         end else if (|m_prod_ff[c][ssu_pkg::CPROD_W-1:ssu_pkg::FRAC+8]) begin
            o_chan_in[c] = 8'hFF;
         end else begin
            o_chan_in[c] = m_prod_ff[c][ssu_pkg::FRAC +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
         for (int i = 0; i < ssu_pkg::POW_STEPS; i++) pw_vld_ff[i] <= 1'b0;
         m_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         t_vld_ff     <= dv_vld_ff[ssu_pkg::DIV_STEPS-1];
         pw_vld_ff[0] <= t_vld_ff;
         for (int i = 1; i < ssu_pkg::POW_STEPS; i++) pw_vld_ff[i] <= pw_vld_ff[i-1];
         m_vld_ff     <= pw_vld_ff[ssu_pkg::POW_STEPS-1];
         rsp_valid_ff <= m_vld_ff;
      end
      if (adv) begin
         t_ff <= t_in;
         for (int i = 0; i < ssu_pkg::POW_STEPS; i++) pw_ff[i] <= pw_in[i];
         for (int c = 0; c < 3; c++) m_prod_ff[c] <= m_prod_in[c];
         m_blk_ff     <= pw_last.blk;
         m_err_ff     <= pw_last.err;
         rsp_red_ff   <= o_chan_in[0];
         rsp_green_ff <= o_chan_in[1];
         rsp_blue_ff  <= o_chan_in[2];
         rsp_err_ff   <= m_err_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_lit_red    = rsp_red_ff;
   assign rsp_lit_green  = rsp_green_ff;
   assign rsp_lit_blue   = rsp_blue_ff;
   assign rsp_kind_error = rsp_err_ff;

   // a kind error (shiny, unshadowed, unknown object) always comes out black
   a_err_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |->
         rsp_red_ff == 8'h00 && rsp_green_ff == 8'h00 && rsp_blue_ff == 8'h00)
      else $error("kind error beat is not black");

   // cosine quotient never exceeds one for nonzero vectors
   a_cos_range: assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[ssu_pkg::DIV_STEPS-1] && !dv_last.side.zero |->
         dv_last.q <= ssu_pkg::ONE_Q16)
      else $error("cosine quotient above one");

   // a held beat freezes the pipe behind it
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(m_vld_ff) && $stable(t_vld_ff)
         && $stable(a_vld_ff))
      else $error("pipe moved while output held");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("valid beat after reset");

endmodule

>>> tb/surface_shading_unit_tb.sv
// surface_shading_unit_tb: randomized and directed check of the shading pipeline
// depends on ssu_pkg and surface_shading_unit; a scoreboard class predicts each beat

module surface_shading_unit_tb;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       kind_err;
   } shade_type;

   typedef logic signed [ssu_pkg::VEC_WIDTH-1:0] comp_type;

   // shading scoreboard: predicts the lit color and holds pending beats
   class shade_board_type;
      shade_type pending[$];
      int        errors;
      int        checked;

      // floor square root, bitwise
      function automatic longint unsigned root_floor(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      // rescale so the largest magnitude sits in [2^14, 2^15)
      function automatic bit rescale(input comp_type raw[3], output longint o[3]);
         longint unsigned mag[3], m, s;
         bit neg[3];
         int k, len;
         m = 0;
         len = 0;
         for (k = 0; k < 3; k++) begin
            neg[k] = raw[k][ssu_pkg::VEC_WIDTH-1];
            mag[k] = neg[k] ? longint'(-longint'(raw[k])) : longint'(raw[k]);
            if (mag[k] > m) m = mag[k];
         end
         if (m == 0) return 0;
         while (len < 64 && (m >> len) != 0) len++;
         for (k = 0; k < 3; k++) begin
            s = (len > ssu_pkg::NORM_BITS) ? (mag[k] >> (len - ssu_pkg::NORM_BITS))
                                           : (mag[k] << (ssu_pkg::NORM_BITS - len));
            o[k] = neg[k] ? -longint'(s) : longint'(s);
         end
         return 1;
      endfunction

      function automatic logic [7:0] scale_chan(longint unsigned b, longint unsigned cf);
         longint unsigned v;
         v = (b * cf) >> 16;
         return (v > 255) ? 8'd255 : v[7:0];
      endfunction

      function automatic shade_type shade(comp_type nv[3], comp_type lv[3], bit shiny,
                                          ssu_pkg::obj_kind_type obj, bit shadow,
                                          logic [7:0] base[3]);
         shade_type r;
         longint n[3], l[3], d, c, t, ofs;
         longint unsigned nn, ll, s, ad, q, p, cf, bb[3];
         int k, pw;
         bit dark;
         r = '{8'd0, 8'd0, 8'd0, 1'b0};
         dark = 0;
         cf = 0;
         if (shadow) return r;
         if (shiny && obj == ssu_pkg::OBJ_UNKNOWN) begin
            r.kind_err = 1;
            return r;
         end
         if (!rescale(nv, n) || !rescale(lv, l)) return r;
         for (k = 0; k < 3; k++) bb[k] = base[k];
         d  = n[0]*l[0] + n[1]*l[1] + n[2]*l[2];
         nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
         ll = l[0]*l[0] + l[1]*l[1] + l[2]*l[2];
         s  = root_floor(nn * ll);
         ad = (d < 0) ? -d : d;
         q  = (s != 0) ? (ad << 16) / s : 0;
         if (q > 65536) q = 65536;
         c = (d < 0) ? -longint'(q) : longint'(q);
         if (!shiny) begin
            if (c <= 0) dark = 1;
            else cf = c;
         end else begin
            ofs = (obj == ssu_pkg::OBJ_SPHERE) ? ssu_pkg::OFS_SPHERE
                : (obj == ssu_pkg::OBJ_BOX) ? ssu_pkg::OFS_BOX : ssu_pkg::OFS_TETRA;
            pw  = (obj == ssu_pkg::OBJ_SPHERE) ? 3 : (obj == ssu_pkg::OBJ_BOX) ? 7 : 6;
            t = c + ofs;
            if (t <= 0) dark = 1;
            else begin
               p = t;
               for (k = 1; k < pw; k++) p = (p * longint'(t)) >> 16;
               cf = p;
               if (obj == ssu_pkg::OBJ_BOX && c >= 65471) bb = '{255, 255, 255};
            end
         end
         if (!dark) begin
            r.red   = scale_chan(bb[0], cf);
            r.green = scale_chan(bb[1], cf);
            r.blue  = scale_chan(bb[2], cf);
         end
         return r;
      endfunction

      function void note_req(comp_type nv[3], comp_type lv[3], bit shiny,
                             ssu_pkg::obj_kind_type obj, bit shadow, logic [7:0] base[3]);
         pending.insert(pending.size(), shade(nv, lv, shiny, obj, shadow, base));
      endfunction

      function void check_rsp(shade_type got);
         shade_type want;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected rsp beat %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.red !== want.red || got.green !== want.green ||
             got.blue !== want.blue || got.kind_err !== want.kind_err) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            errors++;
         end
      endfunction
   endclass

   logic  clock = 0;
   logic  reset = 1;
   logic  req_valid = 0;
   logic  req_stall;
   comp_type req_normal_x = 0, req_normal_y = 0, req_normal_z = 0;
   comp_type req_light_x = 0, req_light_y = 0, req_light_z = 0;
   logic  req_surface_kind = 0;
   logic [1:0] req_object_kind = 0;
   logic  req_in_shadow = 0;
   logic [7:0] req_base_red = 0, req_base_green = 0, req_base_blue = 0;
   logic  rsp_valid;
   logic  rsp_stall = 0;
   logic [7:0] rsp_lit_red, rsp_lit_green, rsp_lit_blue;
   logic  rsp_kind_error;

   shade_board_type board = new();
   int  send_idle_pct = 0;
   int  stall_pct = 0;
   bit  hold_off = 0;
   int  watchdog = 0;
   int  sent = 0;

   always #4 clock = ~clock;

   surface_shading_unit u_top (.*);

   // receiver side: random stall or long hold-off, checks each rsp beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_rsp('{rsp_lit_red, rsp_lit_green, rsp_lit_blue, rsp_kind_error});
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   // watchdog on cycles with no accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (watchdog > 5000) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic comp_type rand_comp();
      case ($urandom_range(5))
         0: return comp_type'($urandom);
         1: return comp_type'($signed($urandom_range(131072)) - 65536);
         2: return comp_type'(32'h8000_0000);
         3: return comp_type'(32'h7fff_ffff);
         4: return comp_type'(0);
         default: return comp_type'($signed($urandom_range(2000)) - 1000);
      endcase
   endfunction

   // offer one beat and wait until it is accepted; valid stays up afterwards
   task automatic send_beat(comp_type nv[3], comp_type lv[3], bit shiny, logic [1:0] obj,
                            bit shadow, logic [7:0] base[3]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_normal_x, req_normal_y, req_normal_z} <= {nv[0], nv[1], nv[2]};
      {req_light_x, req_light_y, req_light_z} <= {lv[0], lv[1], lv[2]};
      req_surface_kind <= shiny;
      req_object_kind <= obj;
      req_in_shadow <= shadow;
      {req_base_red, req_base_green, req_base_blue} <= {base[0], base[1], base[2]};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_req(nv, lv, shiny, ssu_pkg::obj_kind_type'(obj), shadow, base);
      sent++;
   endtask

   // drop valid after the last beat of a sequence
   task automatic release_req();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(int count);
      comp_type nv[3], lv[3];
      logic [7:0] base[3];
      int k, j;
      for (k = 0; k < count; k++) begin
         for (j = 0; j < 3; j++) begin
            nv[j] = rand_comp();
            lv[j] = ($urandom_range(3) == 0) ? rand_comp() : nv[j] + rand_comp() / 64;
            base[j] = 8'($urandom);
         end
         send_beat(nv, lv, 1'($urandom_range(1)), 2'($urandom_range(3)),
                   $urandom_range(9) == 0, base);
      end
      release_req();
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      comp_type nv[3], lv[3], mx, mn;
      logic [7:0] w[3], z[3];
      int o;
      mx = 32'h7fff_ffff;
      mn = 32'h8000_0000;
      w = '{8'd255, 8'd255, 8'd255};
      z = '{8'd0, 8'd0, 8'd0};
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: aligned, opposite, zero length, shadow, extremes, every object
      nv = '{32'sd0, 32'sd0, 32'sd65536};
      for (o = 0; o < 4; o++) begin
         send_beat(nv, nv, 1'b1, 2'(o), 1'b0, w);
         send_beat(nv, '{32'sd0, 32'sd0, -32'sd65536}, 1'b1, 2'(o), 1'b0, w);
      end
      send_beat(nv, nv, 1'b0, 2'd0, 1'b0, w);
      send_beat(nv, '{32'sd0, 32'sd65536, 32'sd0}, 1'b0, 2'd0, 1'b0, w);
      send_beat(nv, '{32'sd0, 32'sd0, -32'sd65536}, 1'b0, 2'd0, 1'b0, w);
      send_beat('{32'sd0, 32'sd0, 32'sd0}, nv, 1'b0, 2'd1, 1'b0, w);
      send_beat(nv, '{32'sd0, 32'sd0, 32'sd0}, 1'b1, 2'd2, 1'b0, w);
      send_beat(nv, nv, 1'b1, 2'd0, 1'b1, w);
      send_beat(nv, nv, 1'b0, 2'd1, 1'b1, z);
      send_beat('{mx, mx, mx}, '{mx, mx, mx}, 1'b1, 2'd2, 1'b0, w);
      send_beat('{mn, mn, mn}, '{mn, mn, mn}, 1'b1, 2'd3, 1'b0, '{8'd1, 8'd128, 8'd254});
      send_beat('{mn, mx, 32'sd1}, '{mx, mn, -32'sd1}, 1'b1, 2'd3, 1'b0, w);
      send_beat('{32'sd1, 32'sd0, 32'sd0}, '{-32'sd1, 32'sd1, 32'sd0}, 1'b1, 2'd1, 1'b0, w);
      send_beat('{32'sd1000, 32'sd1, 32'sd0}, '{32'sd1000, 32'sd0, 32'sd0}, 1'b1, 2'd2,
                1'b0, w);
      release_req();
      drain();

      // random phases with different idle and stall mixes
      send_random(400);
      send_idle_pct = 53;
      send_random(300);
      send_idle_pct = 0;
      stall_pct = 53;
      send_random(300);
      send_idle_pct = 16;
      stall_pct = 16;
      send_random(300);

      // long hold-off at the receiver so the pipeline backs up
      send_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         send_random(120);
      join
      drain();
      send_random(120);

      drain();
      repeat (100) @(posedge clock);
      $display("covered %0d req beats, %0d rsp beats checked, across stall and idle mixes",
               sent, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/ssu_pkg.sv
design/surface_shading_unit.sv
tb/surface_shading_unit_tb.sv
